@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define VFCM_ASSERT(label, ck, rn, expr, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (expr)) else $error(msg);

// Same-cycle implication.
`define VFCM_ASSERT_IMPL(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define VFCM_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ hdl/vfcm_pkg.sv @@
`default_nettype none

package vfcm_pkg;

	// Geometry of the voxel cube
	localparam int unsigned SIDE    = 32;
	localparam int unsigned CELLS   = SIDE * SIDE * SIDE;
	localparam int unsigned ADDR_W  = $clog2(CELLS);

	// Field widths
	localparam int unsigned COORD_W = 5;
	localparam int unsigned MAT_W   = 3;
	localparam int unsigned VERT_W  = 7;
	localparam int unsigned NORM_W  = 3;

	// Per-cell work
	localparam int unsigned N_FACES = 6;
	localparam int unsigned N_VERTS = 6;
	localparam int unsigned N_READS = N_FACES + 1;

	// Decoupling queue depth
	localparam int unsigned FIFO_DEPTH = 2;

	typedef logic [COORD_W-1:0]            coord_t;
	typedef logic [MAT_W-1:0]              mat_t;
	typedef logic [ADDR_W-1:0]             addr_t;
	typedef logic signed [VERT_W-1:0]      vert_t;
	typedef logic [NORM_W-1:0]             norm_t;
	typedef logic [$clog2(N_FACES)-1:0]    face_t;
	typedef logic [$clog2(N_VERTS)-1:0]    vtx_t;
	typedef logic [$clog2(N_READS)-1:0]    rd_idx_t;
	typedef logic [1:0]                    corner_t;
	typedef logic [N_FACES-1:0]            face_mask_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_MESH  = 1'b1
	} op_t;

	// Face positions in emission order (bit positions of face masks)
	localparam int unsigned FACE_BOTTOM = 0;
	localparam int unsigned FACE_TOP    = 1;
	localparam int unsigned FACE_LEFT   = 2;
	localparam int unsigned FACE_RIGHT  = 3;
	localparam int unsigned FACE_FRONT  = 4;
	localparam int unsigned FACE_BACK   = 5;

	// Command handed from front to back
	typedef struct packed {
		op_t        op;
		coord_t     x;
		coord_t     y;
		coord_t     z;
		mat_t       mat;
		face_mask_t bnd;   // face lies on the cube boundary
	} cmd_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_LAST,
		BK_EMIT
	} bk_state_t;

	// Normal code per face, emission order
	localparam norm_t FACE_NORMAL [N_FACES] = '{
		3'd2, 3'd3, 3'd0, 3'd1, 3'd5, 3'd4
	};

	// Faces whose two triangles use the reversed corner order
	localparam face_mask_t FACE_REV = 6'b101010;

	localparam corner_t ORDER_FWD [N_VERTS] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd0};
	localparam corner_t ORDER_REV [N_VERTS] = '{2'd2, 2'd1, 2'd0, 2'd0, 2'd3, 2'd2};

	// Corner offsets, {x,y,z}: 1 means +1, 0 means -1
	localparam logic [2:0] FACE_CORNER [N_FACES][4] = '{
		'{3'b000, 3'b100, 3'b101, 3'b001},
		'{3'b010, 3'b110, 3'b111, 3'b011},
		'{3'b000, 3'b001, 3'b011, 3'b010},
		'{3'b100, 3'b101, 3'b111, 3'b110},
		'{3'b001, 3'b101, 3'b111, 3'b011},
		'{3'b000, 3'b100, 3'b110, 3'b010}
	};

endpackage

`default_nettype wire

@@ hdl/vfcm_in_if.sv @@
`default_nettype none

interface vfcm_in_if;
	logic             valid;
	logic             ready;
	logic             opcode;
	vfcm_pkg::coord_t cell_x;
	vfcm_pkg::coord_t cell_y;
	vfcm_pkg::coord_t cell_z;
	vfcm_pkg::mat_t   material_in;

	modport source (
		output valid, opcode, cell_x, cell_y, cell_z, material_in,
		input  ready
	);
	modport sink (
		input  valid, opcode, cell_x, cell_y, cell_z, material_in,
		output ready
	);
endinterface

`default_nettype wire

@@ hdl/vfcm_out_if.sv @@
`default_nettype none

interface vfcm_out_if;
	logic              valid;
	logic              ready;
	vfcm_pkg::vert_t   vert_x;
	vfcm_pkg::vert_t   vert_y;
	vfcm_pkg::vert_t   vert_z;
	vfcm_pkg::norm_t   face_normal;
	vfcm_pkg::mat_t    material_out;
	logic              last_vertex;

	modport source (
		output valid, vert_x, vert_y, vert_z, face_normal, material_out, last_vertex,
		input  ready
	);
	modport sink (
		input  valid, vert_x, vert_y, vert_z, face_normal, material_out, last_vertex,
		output ready
	);
endinterface

`default_nettype wire

@@ hdl/vfcm_ram.sv @@
`default_nettype none

module vfcm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hdl/vfcm_front.sv @@
`default_nettype none

module vfcm_front (
	input  logic            clk,
	input  logic            arst_n,
	vfcm_in_if.sink         item,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output vfcm_pkg::cmd_t  cmd
);

	logic           vld_q;
	vfcm_pkg::cmd_t cmd_q;
	vfcm_pkg::cmd_t cmd_d;
	logic           in_range;

	// Classify: drop cells outside the cube, flag boundary faces
	always_comb begin
		in_range = (32'(item.cell_x) < vfcm_pkg::SIDE) &&
			(32'(item.cell_y) < vfcm_pkg::SIDE) &&
			(32'(item.cell_z) < vfcm_pkg::SIDE);
		cmd_d.op  = vfcm_pkg::op_t'(item.opcode);
		cmd_d.x   = item.cell_x;
		cmd_d.y   = item.cell_y;
		cmd_d.z   = item.cell_z;
		cmd_d.mat = item.material_in;
		cmd_d.bnd = '0;
		cmd_d.bnd[vfcm_pkg::FACE_BOTTOM] = (item.cell_y == '0);
		cmd_d.bnd[vfcm_pkg::FACE_TOP]    = (32'(item.cell_y) == vfcm_pkg::SIDE - 1);
		cmd_d.bnd[vfcm_pkg::FACE_LEFT]   = (item.cell_x == '0);
		cmd_d.bnd[vfcm_pkg::FACE_RIGHT]  = (32'(item.cell_x) == vfcm_pkg::SIDE - 1);
		cmd_d.bnd[vfcm_pkg::FACE_FRONT]  = (32'(item.cell_z) == vfcm_pkg::SIDE - 1);
		cmd_d.bnd[vfcm_pkg::FACE_BACK]   = (item.cell_z == '0);
	end

	assign item.ready = !vld_q || cmd_ready;

	// Holding register toward the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (item.ready) begin
			vld_q <= item.valid && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_q <= cmd_d;
		end
	end

	assign cmd_valid = vld_q;
	assign cmd       = cmd_q;

endmodule

`default_nettype wire

@@ hdl/vfcm_fifo.sv @@
`default_nettype none
`include "assert_macros.svh"

module vfcm_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  vfcm_pkg::cmd_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output vfcm_pkg::cmd_t  pop_data
);

	localparam int unsigned PTR_W = (vfcm_pkg::FIFO_DEPTH > 1) ?
		$clog2(vfcm_pkg::FIFO_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(vfcm_pkg::FIFO_DEPTH + 1);

	vfcm_pkg::cmd_t    entries_q [vfcm_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = (32'(count_q) != vfcm_pkg::FIFO_DEPTH);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entries_q[rd_ptr_q];

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == vfcm_pkg::FIFO_DEPTH - 1) ? '0 :
					wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == vfcm_pkg::FIFO_DEPTH - 1) ? '0 :
					rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	`VFCM_ASSERT(a_count_bound, clk, arst_n, 32'(count_q) <= vfcm_pkg::FIFO_DEPTH, "queue overfilled")
	`VFCM_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

@@ hdl/vfcm_back.sv @@
`default_nettype none
`include "assert_macros.svh"

module vfcm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  vfcm_pkg::cmd_t  cmd,
	vfcm_out_if.source      vert
);

	// Read slots: the cell itself, then its neighbors in face order
	localparam vfcm_pkg::rd_idx_t RD_CENTER = 3'd0;
	localparam vfcm_pkg::rd_idx_t RD_BOTTOM = 3'd1;
	localparam vfcm_pkg::rd_idx_t RD_TOP    = 3'd2;
	localparam vfcm_pkg::rd_idx_t RD_LEFT   = 3'd3;
	localparam vfcm_pkg::rd_idx_t RD_RIGHT  = 3'd4;
	localparam vfcm_pkg::rd_idx_t RD_FRONT  = 3'd5;
	localparam vfcm_pkg::rd_idx_t RD_BACK   = 3'd6;

	vfcm_pkg::bk_state_t  state_q;
	vfcm_pkg::bk_state_t  state_d;

	vfcm_pkg::coord_t     x_q;
	vfcm_pkg::coord_t     y_q;
	vfcm_pkg::coord_t     z_q;
	vfcm_pkg::mat_t       mat_q;
	vfcm_pkg::face_mask_t vis_q;
	vfcm_pkg::face_mask_t vis_d;
	vfcm_pkg::vert_t      base_x_q;
	vfcm_pkg::vert_t      base_y_q;
	vfcm_pkg::vert_t      base_z_q;
	vfcm_pkg::rd_idx_t    rd_cnt_q;
	vfcm_pkg::rd_idx_t    rd_idx_s1;
	logic                 rd_vld_s1;
	vfcm_pkg::face_t      face_q;
	vfcm_pkg::vtx_t       vtx_q;

	logic                 out_vld_q;
	vfcm_pkg::vert_t      vx_q;
	vfcm_pkg::vert_t      vy_q;
	vfcm_pkg::vert_t      vz_q;
	vfcm_pkg::norm_t      norm_q;
	vfcm_pkg::mat_t       mat_out_q;
	logic                 last_q;

	logic                 ram_we;
	vfcm_pkg::addr_t      waddr;
	vfcm_pkg::addr_t      raddr;
	vfcm_pkg::mat_t       rd_data;
	vfcm_pkg::coord_t     nx;
	vfcm_pkg::coord_t     ny;
	vfcm_pkg::coord_t     nz;

	logic                 load_cmd;
	logic                 advance;
	logic                 emit_fire;
	logic                 last_v;
	vfcm_pkg::face_mask_t later;
	vfcm_pkg::face_t      next_face;
	vfcm_pkg::corner_t    corner_sel;
	logic [2:0]           hi;

	function automatic vfcm_pkg::addr_t cell_addr(
		input vfcm_pkg::coord_t cx,
		input vfcm_pkg::coord_t cy,
		input vfcm_pkg::coord_t cz
	);
		return vfcm_pkg::ADDR_W'(cz) * vfcm_pkg::ADDR_W'(vfcm_pkg::SIDE * vfcm_pkg::SIDE) +
			vfcm_pkg::ADDR_W'(cy) * vfcm_pkg::ADDR_W'(vfcm_pkg::SIDE) +
			vfcm_pkg::ADDR_W'(cx);
	endfunction

	function automatic vfcm_pkg::face_t first_face(input vfcm_pkg::face_mask_t m);
		vfcm_pkg::face_t r;
		r = '0;
		for (int i = vfcm_pkg::N_FACES - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = vfcm_pkg::face_t'(i);
			end
		end
		return r;
	endfunction

	// Voxel store
	vfcm_ram #(
		.WIDTH (vfcm_pkg::MAT_W),
		.DEPTH (vfcm_pkg::CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (cmd.mat),
		.raddr (raddr),
		.rdata (rd_data)
	);

	assign waddr = cell_addr(cmd.x, cmd.y, cmd.z);

	// Neighbor address for the current read slot
	always_comb begin
		nx = x_q;
		ny = y_q;
		nz = z_q;
		case (rd_cnt_q)
			RD_CENTER: ;
			RD_BOTTOM: ny = y_q - 1'b1;
			RD_TOP:    ny = y_q + 1'b1;
			RD_LEFT:   nx = x_q - 1'b1;
			RD_RIGHT:  nx = x_q + 1'b1;
			RD_FRONT:  nz = z_q + 1'b1;
			RD_BACK:   nz = z_q - 1'b1;
			default:   ;
		endcase
		raddr = cell_addr(nx, ny, nz);
	end

	// Visibility update from returning neighbor data
	always_comb begin
		vis_d = vis_q;
		if (rd_vld_s1) begin
			for (int i = 0; i < vfcm_pkg::N_FACES; i++) begin
				if (rd_idx_s1 == vfcm_pkg::rd_idx_t'(i + 1) && rd_data == '0) begin
					vis_d[i] = 1'b1;
				end
			end
		end
	end

	// Emission bookkeeping: faces after this one, corner selection
	always_comb begin
		for (int i = 0; i < vfcm_pkg::N_FACES; i++) begin
			later[i] = vis_q[i] && (vfcm_pkg::face_t'(i) > face_q);
		end
		next_face  = first_face(later);
		last_v     = (32'(vtx_q) == vfcm_pkg::N_VERTS - 1) && (later == '0);
		corner_sel = vfcm_pkg::FACE_REV[face_q] ? vfcm_pkg::ORDER_REV[vtx_q] :
			vfcm_pkg::ORDER_FWD[vtx_q];
		hi         = vfcm_pkg::FACE_CORNER[face_q][corner_sel];
	end

	assign advance = !out_vld_q || vert.ready;

	// Sequencer next state and controls
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		ram_we    = 1'b0;
		load_cmd  = 1'b0;
		emit_fire = 1'b0;
		case (state_q)
			vfcm_pkg::BK_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					if (cmd.op == vfcm_pkg::OP_WRITE) begin
						ram_we = 1'b1;
					end else begin
						load_cmd = 1'b1;
						state_d  = vfcm_pkg::BK_READ;
					end
				end
			end
			vfcm_pkg::BK_READ: begin
				if (rd_cnt_q == RD_BACK) begin
					state_d = vfcm_pkg::BK_LAST;
				end
			end
			vfcm_pkg::BK_LAST: begin
				if (mat_q != '0 && vis_d != '0) begin
					state_d = vfcm_pkg::BK_EMIT;
				end else begin
					state_d = vfcm_pkg::BK_IDLE;
				end
			end
			vfcm_pkg::BK_EMIT: begin
				if (advance) begin
					emit_fire = 1'b1;
					if (last_v) begin
						state_d = vfcm_pkg::BK_IDLE;
					end
				end
			end
			default: state_d = vfcm_pkg::BK_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= vfcm_pkg::BK_IDLE;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == vfcm_pkg::BK_READ);
			if (emit_fire) begin
				out_vld_q <= 1'b1;
			end else if (vert.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_cnt_q;
		if (load_cmd) begin
			x_q      <= cmd.x;
			y_q      <= cmd.y;
			z_q      <= cmd.z;
			vis_q    <= cmd.bnd;
			rd_cnt_q <= RD_CENTER;
			base_x_q <= vfcm_pkg::vert_t'({cmd.x, 1'b0}) - vfcm_pkg::vert_t'(vfcm_pkg::SIDE);
			base_y_q <= vfcm_pkg::vert_t'({cmd.y, 1'b0}) - vfcm_pkg::vert_t'(vfcm_pkg::SIDE);
			base_z_q <= vfcm_pkg::vert_t'({cmd.z, 1'b0}) - vfcm_pkg::vert_t'(vfcm_pkg::SIDE);
		end else if (state_q == vfcm_pkg::BK_READ) begin
			rd_cnt_q <= rd_cnt_q + 1'b1;
		end
		if (rd_vld_s1) begin
			vis_q <= vis_d;
			if (rd_idx_s1 == RD_CENTER) begin
				mat_q <= rd_data;
			end
		end
		if (state_q == vfcm_pkg::BK_LAST) begin
			face_q <= first_face(vis_d);
			vtx_q  <= '0;
		end
		if (emit_fire) begin
			vx_q      <= base_x_q + (hi[2] ? vfcm_pkg::vert_t'(1) : vfcm_pkg::vert_t'(-1));
			vy_q      <= base_y_q + (hi[1] ? vfcm_pkg::vert_t'(1) : vfcm_pkg::vert_t'(-1));
			vz_q      <= base_z_q + (hi[0] ? vfcm_pkg::vert_t'(1) : vfcm_pkg::vert_t'(-1));
			norm_q    <= vfcm_pkg::FACE_NORMAL[face_q];
			mat_out_q <= mat_q;
			last_q    <= last_v;
			if (32'(vtx_q) == vfcm_pkg::N_VERTS - 1) begin
				vtx_q  <= '0;
				face_q <= next_face;
			end else begin
				vtx_q <= vtx_q + 1'b1;
			end
		end
	end

	assign vert.valid        = out_vld_q;
	assign vert.vert_x       = vx_q;
	assign vert.vert_y       = vy_q;
	assign vert.vert_z       = vz_q;
	assign vert.face_normal  = norm_q;
	assign vert.material_out = mat_out_q;
	assign vert.last_vertex  = last_q;

	`VFCM_ASSERT_IMPL(a_emit_visible, clk, arst_n, state_q == vfcm_pkg::BK_EMIT, vis_q[face_q], "emitting a hidden face")
	`VFCM_ASSERT_IMPL(a_load_in_emit, clk, arst_n, $rose(out_vld_q), $past(state_q) == vfcm_pkg::BK_EMIT, "vertex loaded outside emission")
	`VFCM_ASSERT_NEXT(a_last_ends, clk, arst_n, emit_fire && last_v, state_q == vfcm_pkg::BK_IDLE, "sequencer did not finish after last vertex")

endmodule

`default_nettype wire

@@ hdl/voxel_face_culling_mesher_core.sv @@
`default_nettype none

// Voxel face-culling mesher. A 32x32x32 store of 3-bit materials takes write
// transactions (opcode 0) and mesh transactions (opcode 1); a mesh transaction
// on a non-air cell yields six vertices per visible face, in the order bottom,
// top, left, right, front, back, with last_vertex set on the final one. The
// store has no reset: mesh a cell only after it and its in-cube neighbors
// were written. Input transactions pass a holding register and a two-entry
// queue, so the input keeps flowing while the back end works. The back end
// takes a write in its idle state. Before its first vertex a mesh passes
// through taking the command, seven store reads (the cell and its six
// neighbors, one read per cycle on the single read port), and a last step
// while the final read returns and the visibility decision is made. Then it
// takes one cycle per vertex, up to 36, subject to backpressure on the output
// register. An air or fully enclosed cell ends after that decision.
module voxel_face_culling_mesher_core (
	input  logic        clk,
	input  logic        arst_n,
	vfcm_in_if.sink     item,
	vfcm_out_if.source  vert
);

	logic           fr_valid;
	logic           fr_ready;
	vfcm_pkg::cmd_t fr_cmd;
	logic           q_valid;
	logic           q_ready;
	vfcm_pkg::cmd_t q_cmd;

	// Accept and classify
	vfcm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd       (fr_cmd)
	);

	// Decoupling queue
	vfcm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_cmd)
	);

	// Store access and vertex emission
	vfcm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.vert      (vert)
	);

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import vfcm_pkg::*;

	// Own view of the face geometry
	localparam norm_t NRM_LEFT   = 3'd0;
	localparam norm_t NRM_RIGHT  = 3'd1;
	localparam norm_t NRM_BOTTOM = 3'd2;
	localparam norm_t NRM_TOP    = 3'd3;
	localparam norm_t NRM_BACK   = 3'd4;
	localparam norm_t NRM_FRONT  = 3'd5;

	// Corners per face as {x,y,z}, 1 = +1 and 0 = -1; corner 0 in the low bits
	localparam logic [71:0] CUBE_CORNERS = {
		12'b010_110_100_000,    // back
		12'b011_111_101_001,    // front
		12'b110_111_101_100,    // right
		12'b010_011_001_000,    // left
		12'b011_111_110_010,    // top
		12'b001_101_100_000     // bottom
	};
	// Corner sequence for the two triangles, vertex 0 in the low bits
	localparam logic [11:0] FWD_SEQ = {2'd0, 2'd3, 2'd2, 2'd2, 2'd1, 2'd0};
	localparam logic [11:0] REV_SEQ = {2'd2, 2'd3, 2'd0, 2'd0, 2'd1, 2'd2};

	localparam int TAIL_CYCLES  = 64;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int TIMEOUT_NS   = 10_000_000;

	typedef struct packed {
		vert_t vx;
		vert_t vy;
		vert_t vz;
		norm_t normal;
		mat_t  material;
		logic  last;
	} vertex_t;

	logic clk;
	logic arst_n;

	vfcm_in_if  item_ch ();
	vfcm_out_if vert_ch ();

	voxel_face_culling_mesher_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.vert   (vert_ch)
	);

	// Shadow of the voxel store and the vertices still owed by the block
	mat_t    voxel_mem [CELLS];
	bit      cell_written [CELLS];
	vertex_t pending_verts [$];

	int sender_idle_pct;
	int recv_stall_pct;
	int fail_count;
	int items_sent;
	int writes_done;
	int meshes_done;
	int meshes_drawn;
	int verts_checked;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("testbench: errors");
		$finish;
	end

	function automatic int cell_index(int x, int y, int z);
		return (z * int'(SIDE) + y) * int'(SIDE) + x;
	endfunction

	function automatic bit in_cube(int x, int y, int z);
		return x >= 0 && y >= 0 && z >= 0 &&
			x < int'(SIDE) && y < int'(SIDE) && z < int'(SIDE);
	endfunction

	function automatic mat_t pick_material(int air_pct);
		if ($urandom_range(99) < air_pct)
			return '0;
		return mat_t'($urandom_range(7, 1));
	endfunction

	// Update the shadow store, and for a mesh queue the vertices it must produce
	function automatic void predict_item(op_t op, coord_t x, coord_t y, coord_t z, mat_t m);
		int         idx;
		int         dx, dy, dz;
		int         total, n, c;
		int         vx, vy, vz;
		logic [2:0] cb;
		logic [5:0] visible;
		logic [5:0] reversed;
		norm_t      nrm [6];
		mat_t       mat;
		vertex_t    v;

		idx = cell_index(x, y, z);
		if (op == OP_WRITE) begin
			voxel_mem[idx] = m;
			cell_written[idx] = 1'b1;
			writes_done++;
			return;
		end
		meshes_done++;
		mat = voxel_mem[idx];
		if (mat == '0)
			return;

		// A face shows when it sits on the boundary or faces air
		reversed = '0;
		for (int f = 0; f < 6; f++) begin
			dx = 0; dy = 0; dz = 0;
			case (f)
				FACE_BOTTOM: begin dy = -1; nrm[f] = NRM_BOTTOM; end
				FACE_TOP:    begin dy = 1;  nrm[f] = NRM_TOP;    reversed[f] = 1'b1; end
				FACE_LEFT:   begin dx = -1; nrm[f] = NRM_LEFT;   end
				FACE_RIGHT:  begin dx = 1;  nrm[f] = NRM_RIGHT;  reversed[f] = 1'b1; end
				FACE_FRONT:  begin dz = 1;  nrm[f] = NRM_FRONT;  end
				default:     begin dz = -1; nrm[f] = NRM_BACK;   reversed[f] = 1'b1; end
			endcase
			if (!in_cube(int'(x) + dx, int'(y) + dy, int'(z) + dz))
				visible[f] = 1'b1;
			else
				visible[f] = voxel_mem[cell_index(int'(x) + dx, int'(y) + dy,
					int'(z) + dz)] == '0;
		end

		total = 6 * $countones(visible);
		if (total > 0)
			meshes_drawn++;
		n = 0;
		for (int f = 0; f < 6; f++) begin
			if (!visible[f])
				continue;
			for (int k = 0; k < 6; k++) begin
				c = reversed[f] ? REV_SEQ[2*k +: 2] : FWD_SEQ[2*k +: 2];
				cb = CUBE_CORNERS[12*f + 3*c +: 3];
				vx = 2 * int'(x) - int'(SIDE) + (cb[2] ? 1 : -1);
				vy = 2 * int'(y) - int'(SIDE) + (cb[1] ? 1 : -1);
				vz = 2 * int'(z) - int'(SIDE) + (cb[0] ? 1 : -1);
				v.vx = vx[6:0];
				v.vy = vy[6:0];
				v.vz = vz[6:0];
				v.normal = nrm[f];
				v.material = mat;
				v.last = (n == total - 1);
				pending_verts.insert(pending_verts.size(), v);
				n++;
			end
		end
	endfunction

	// Drive one transaction, with a random gap first, and wait for acceptance
	task automatic send_item(op_t op, coord_t x, coord_t y, coord_t z, mat_t m);
		if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			item_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct);
		end
		item_ch.valid       <= 1'b1;
		item_ch.opcode      <= op;
		item_ch.cell_x      <= x;
		item_ch.cell_y      <= y;
		item_ch.cell_z      <= z;
		item_ch.material_in <= m;
		do
			@(posedge clk);
		while (!item_ch.ready);
		predict_item(op, x, y, z, m);
		items_sent++;
	endtask

	// Mesh a cell; any unwritten cell it reads gets written first
	task automatic mesh_cell(int x, int y, int z);
		int nx, ny, nz;

		for (int p = 0; p < 7; p++) begin
			nx = x; ny = y; nz = z;
			case (p)
				1: ny = y - 1;
				2: ny = y + 1;
				3: nx = x - 1;
				4: nx = x + 1;
				5: nz = z + 1;
				6: nz = z - 1;
				default: ;
			endcase
			if (in_cube(nx, ny, nz) && !cell_written[cell_index(nx, ny, nz)])
				send_item(OP_WRITE, coord_t'(nx), coord_t'(ny), coord_t'(nz),
					pick_material(p == 0 ? 15 : 40));
		end
		send_item(OP_MESH, coord_t'(x), coord_t'(y), coord_t'(z), mat_t'($urandom_range(7)));
	endtask

	// Hold the input off until every owed vertex has come, then let the block settle
	task automatic drain_results();
		int waited;

		waited = 0;
		item_ch.valid <= 1'b0;
		while (pending_verts.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic void check_field(string name, logic signed [7:0] want,
		logic signed [7:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Receiver readiness follows the current stall rate
	always @(posedge clk)
		vert_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	// Compare each accepted vertex with the oldest one owed
	always @(posedge clk) begin : vertex_check
		vertex_t want;

		if (arst_n && vert_ch.valid && vert_ch.ready) begin
			if (pending_verts.size() == 0) begin
				$error("vertex transaction with none expected: x %0d y %0d z %0d",
					vert_ch.vert_x, vert_ch.vert_y, vert_ch.vert_z);
				fail_count++;
			end else begin
				want = pending_verts.pop_front();
				check_field("vert_x", want.vx, vert_ch.vert_x);
				check_field("vert_y", want.vy, vert_ch.vert_y);
				check_field("vert_z", want.vz, vert_ch.vert_z);
				check_field("face_normal", want.normal, vert_ch.face_normal);
				check_field("material_out", want.material, vert_ch.material_out);
				check_field("last_vertex", want.last, vert_ch.last_vertex);
				verts_checked++;
			end
		end
	end

	// Opposite corners of the cube: all faces open, then only the boundary faces
	task automatic test_boundary_corners();
		send_item(OP_WRITE, 5'd0, 5'd0, 5'd0, 3'd7);
		send_item(OP_WRITE, 5'd1, 5'd0, 5'd0, 3'd0);
		send_item(OP_WRITE, 5'd0, 5'd1, 5'd0, 3'd0);
		send_item(OP_WRITE, 5'd0, 5'd0, 5'd1, 3'd0);
		mesh_cell(0, 0, 0);
		send_item(OP_WRITE, 5'd31, 5'd31, 5'd31, 3'd1);
		send_item(OP_WRITE, 5'd30, 5'd31, 5'd31, 3'd5);
		send_item(OP_WRITE, 5'd31, 5'd30, 5'd31, 3'd5);
		send_item(OP_WRITE, 5'd31, 5'd31, 5'd30, 3'd5);
		mesh_cell(31, 31, 31);
	endtask

	// A cell buried on all six sides gives nothing; cleared to air it still gives nothing
	task automatic test_enclosed_and_air();
		send_item(OP_WRITE, 5'd10, 5'd10, 5'd10, 3'd3);
		send_item(OP_WRITE, 5'd9, 5'd10, 5'd10, 3'd6);
		send_item(OP_WRITE, 5'd11, 5'd10, 5'd10, 3'd2);
		send_item(OP_WRITE, 5'd10, 5'd9, 5'd10, 3'd4);
		send_item(OP_WRITE, 5'd10, 5'd11, 5'd10, 3'd7);
		send_item(OP_WRITE, 5'd10, 5'd10, 5'd9, 3'd5);
		send_item(OP_WRITE, 5'd10, 5'd10, 5'd11, 3'd1);
		mesh_cell(10, 10, 10);
		send_item(OP_WRITE, 5'd10, 5'd10, 5'd10, 3'd0);
		mesh_cell(10, 10, 10);
	endtask

	// Random writes and meshes clustered in small boxes, some spread over the cube
	task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
		int start, step, r;
		int bx, by, bz;

		sender_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start = items_sent;
		step = 0;
		while (items_sent - start < n_items) begin
			if (step % 24 == 0) begin
				r = $urandom_range(3);
				bx = (r == 0) ? 0 : (r == 1) ? int'(SIDE) - 4 : $urandom_range(SIDE - 4);
				r = $urandom_range(3);
				by = (r == 0) ? 0 : (r == 1) ? int'(SIDE) - 4 : $urandom_range(SIDE - 4);
				r = $urandom_range(3);
				bz = (r == 0) ? 0 : (r == 1) ? int'(SIDE) - 4 : $urandom_range(SIDE - 4);
			end
			r = $urandom_range(99);
			if (r < 55)
				mesh_cell(bx + $urandom_range(3), by + $urandom_range(3),
					bz + $urandom_range(3));
			else if (r < 85)
				send_item(OP_WRITE, coord_t'(bx + $urandom_range(3)),
					coord_t'(by + $urandom_range(3)), coord_t'(bz + $urandom_range(3)),
					pick_material(35));
			else if (r < 93)
				send_item(OP_WRITE, coord_t'($urandom_range(31)), coord_t'($urandom_range(31)),
					coord_t'($urandom_range(31)), mat_t'($urandom_range(7)));
			else
				mesh_cell($urandom_range(31), $urandom_range(31), $urandom_range(31));
			step++;
		end
	endtask

	initial begin
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		items_sent = 0;
		writes_done = 0;
		meshes_done = 0;
		meshes_drawn = 0;
		verts_checked = 0;
		arst_n              <= 1'b0;
		item_ch.valid       <= 1'b0;
		item_ch.opcode      <= OP_WRITE;
		item_ch.cell_x      <= '0;
		item_ch.cell_y      <= '0;
		item_ch.cell_z      <= '0;
		item_ch.material_in <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_boundary_corners();
		test_enclosed_and_air();
		drain_results();
		test_random_traffic(70, 0, 0);
		drain_results();
		test_random_traffic(75, 55, 0);
		test_random_traffic(75, 0, 55);
		drain_results();
		test_random_traffic(70, 7, 7);
		drain_results();

		if (pending_verts.size() != 0) begin
			$error("%0d expected vertices never arrived", pending_verts.size());
			fail_count++;
		end
		$display("run: %0d transactions (%0d writes, %0d meshes, %0d with visible faces)",
			items_sent, writes_done, meshes_done, meshes_drawn);
		$display("run: %0d vertices compared, %0d mismatches", verts_checked, fail_count);
		if (fail_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
